>>> design/wsdf_pkg.sv
// Shared constants and result type for the WebSocket frame deframer.
package wsdf_pkg;

	localparam int unsigned LENGTH_BITS_DEFAULT = 64;
	localparam logic [31:0] MAX_MSG_RESET       = 32'd65536;

	localparam logic [3:0] OPC_CLOSE = 4'h8;
	localparam logic [3:0] OPC_PING  = 4'h9;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [1:0] EV_NONE      = 2'd0;
	localparam logic [1:0] EV_CLOSE     = 2'd1;
	localparam logic [1:0] EV_PING      = 2'd2;
	localparam logic [1:0] EV_TOO_LARGE = 2'd3;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] payload_byte;
		logic [3:0] message_opcode;
		logic       frame_end;
		logic       message_end;
		logic [1:0] event_res;
	} res_t;

endpackage

>>> design/websocket_frame_deframer_unit.sv
// WebSocket frame deframer: byte-serial frame parser, unmasking and event flags.
//
// Input channel: one received byte per item on data_byte, taken at a clock edge
// where in_valid is high and in_stall is low. Header bytes give no result except
// the byte that completes the header of a zero-length frame or the length of an
// oversize message. Each payload byte gives one result with the unmasked byte and
// the message opcode.
// Output channel: one result per item on out_valid/out_stall with has_byte,
// payload_byte, message_opcode, frame_end, message_end and event_res.
// Throughput: one byte per cycle while in_stall is low; the whole parse step for
// a byte sits between the state registers and the output register. A result is
// registered in the output register, or in the skid register on a stall.
// The output register is backed by a one-entry skid register, so the input keeps
// flowing for one result while the receiver stalls; in_stall rises only once the
// skid entry is full, and falls on the cycle after the receiver drains it.
// max_message_bytes is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while idle, which the block does not enforce. Once a close message ends or a
// message is too large, all further bytes are dropped. Reset (arst_n low) clears parse
// state, empties both result registers and restores max_message_bytes to 65536.
module websocket_frame_deframer_unit #(
	parameter int unsigned LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        has_byte,
	output logic [7:0]  payload_byte,
	output logic [3:0]  message_opcode,
	output logic        frame_end,
	output logic        message_end,
	output logic [1:0]  event_res
);
	import wsdf_pkg::*;

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXT     = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_DEAD    = 3'd5;

	localparam int unsigned CW = (LENGTH_BITS > 33) ? LENGTH_BITS : 33;

	logic [31:0]            max_q;
	logic [2:0]             phase_q, phase_n;
	logic [2:0]             cnt_q, cnt_n;
	logic [LENGTH_BITS-1:0] rem_q, rem_n;
	logic                   ovf_q, ovf_n;
	logic [31:0]            key_q, key_n;
	logic                   mask_en_q, mask_en_n;
	logic [1:0]             pos_q, pos_n;
	logic                   fin_q, fin_n;
	logic [3:0]             held_q, held_n;
	logic [32:0]            total_q, total_n;

	logic       accept;
	logic       res_v;
	res_t       res;
	logic       do_len, do_hdr, do_end;
	logic       end_has;
	logic [7:0] end_byte;
	logic [7:0] key_byte;
	logic [CW-1:0] len_ext, room_ext;
	logic       too_large;

	res_t out_s1, skid_q;
	logic ov_s1, sk_q;
	logic pop;

	assign accept = in_valid && !in_stall;
	assign in_stall = sk_q;
	assign pop = ov_s1 && !out_stall;

	assign key_byte = 8'(key_q >> {~pos_q, 3'b000});
	assign len_ext  = CW'(rem_n);
	assign room_ext = CW'(max_q) - CW'(total_q);

	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		rem_n     = rem_q;
		ovf_n     = ovf_q;
		key_n     = key_q;
		mask_en_n = mask_en_q;
		pos_n     = pos_q;
		fin_n     = fin_q;
		held_n    = held_q;
		total_n   = total_q;
		res_v     = 1'b0;
		res       = '0;
		do_len    = 1'b0;
		do_hdr    = 1'b0;
		do_end    = 1'b0;
		end_has   = 1'b0;
		end_byte  = 8'd0;
		too_large = 1'b0;

		unique case (phase_q)
			PH_HDR0: begin
				fin_n = data_byte[7];
				if (held_q == 4'd0) begin
					held_n = data_byte[3:0];
				end
				phase_n = PH_HDR1;
			end
			PH_HDR1: begin
				mask_en_n = data_byte[7];
				ovf_n     = 1'b0;
				rem_n     = '0;
				if (data_byte[6:0] == LEN7_EXT16) begin
					cnt_n   = 3'd1;
					phase_n = PH_EXT;
				end else if (data_byte[6:0] == LEN7_EXT64) begin
					cnt_n   = 3'd7;
					phase_n = PH_EXT;
				end else begin
					rem_n  = LENGTH_BITS'(data_byte[6:0]);
					do_len = 1'b1;
				end
			end
			PH_EXT: begin
				rem_n = {rem_q[LENGTH_BITS-9:0], data_byte};
				ovf_n = ovf_q || (rem_q[LENGTH_BITS-1 -: 8] != 8'd0);
				if (cnt_q != 3'd0) begin
					cnt_n = cnt_q - 3'd1;
				end else begin
					do_len = 1'b1;
				end
			end
			PH_MASK: begin
				key_n = {key_q[23:0], data_byte};
				if (cnt_q != 3'd0) begin
					cnt_n = cnt_q - 3'd1;
				end else begin
					do_hdr = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				rem_n = rem_q - LENGTH_BITS'(1);
				pos_n = pos_q + 2'd1;
				if (rem_n == '0) begin
					do_end   = 1'b1;
					end_has  = 1'b1;
					end_byte = data_byte ^ (mask_en_q ? key_byte : 8'd0);
				end else begin
					res_v              = 1'b1;
					res.has_byte       = 1'b1;
					res.payload_byte   = data_byte ^ (mask_en_q ? key_byte : 8'd0);
					res.message_opcode = held_q;
					res.event_res      = EV_NONE;
				end
			end
			default: begin
				phase_n = PH_DEAD;
			end
		endcase

		if (do_len) begin
			too_large = ovf_n || (CW'(total_q) > CW'(max_q)) || (len_ext > room_ext);
			if (too_large) begin
				res_v              = 1'b1;
				res.message_opcode = held_n;
				res.event_res      = EV_TOO_LARGE;
				phase_n            = PH_DEAD;
			end else begin
				total_n = total_q + len_ext[32:0];
				key_n   = '0;
				if (mask_en_n) begin
					cnt_n   = 3'd3;
					phase_n = PH_MASK;
				end else begin
					do_hdr = 1'b1;
				end
			end
		end

		if (do_hdr) begin
			pos_n = 2'd0;
			if (rem_n == '0) begin
				do_end = 1'b1;
			end else begin
				phase_n = PH_PAYLOAD;
			end
		end

		if (do_end) begin
			res_v              = 1'b1;
			res.has_byte       = end_has;
			res.payload_byte   = end_byte;
			res.message_opcode = held_n;
			res.frame_end      = 1'b1;
			res.message_end    = fin_n;
			res.event_res      = EV_NONE;
			phase_n            = PH_HDR0;
			if (fin_n) begin
				if (held_n == OPC_CLOSE) begin
					res.event_res = EV_CLOSE;
					phase_n       = PH_DEAD;
				end else if (held_n == OPC_PING) begin
					res.event_res = EV_PING;
				end
				held_n  = 4'd0;
				total_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q     <= MAX_MSG_RESET;
			phase_q   <= PH_HDR0;
			cnt_q     <= '0;
			rem_q     <= '0;
			ovf_q     <= 1'b0;
			key_q     <= '0;
			mask_en_q <= 1'b0;
			pos_q     <= '0;
			fin_q     <= 1'b0;
			held_q    <= '0;
			total_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q   <= phase_n;
				cnt_q     <= cnt_n;
				rem_q     <= rem_n;
				ovf_q     <= ovf_n;
				key_q     <= key_n;
				mask_en_q <= mask_en_n;
				pos_q     <= pos_n;
				fin_q     <= fin_n;
				held_q    <= held_n;
				total_q   <= total_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s1 <= 1'b0;
			sk_q  <= 1'b0;
		end else begin
			if (pop || !ov_s1) begin
				if (sk_q) begin
					ov_s1 <= 1'b1;
					sk_q  <= 1'b0;
				end else begin
					ov_s1 <= accept && res_v;
				end
			end else if (accept && res_v) begin
				sk_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !ov_s1) begin
			out_s1 <= sk_q ? skid_q : res;
		end else if (accept && res_v) begin
			skid_q <= res;
		end
	end

	assign out_valid      = ov_s1;
	assign has_byte       = out_s1.has_byte;
	assign payload_byte   = out_s1.payload_byte;
	assign message_opcode = out_s1.message_opcode;
	assign frame_end      = out_s1.frame_end;
	assign message_end    = out_s1.message_end;
	assign event_res      = out_s1.event_res;

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_q |-> ov_s1)
		else $error("skid entry held while output register empty");

	a_dead_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DEAD |=> phase_q == PH_DEAD)
		else $error("parser left the discard state");

	a_empty_result_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte && event_res != EV_TOO_LARGE) |-> frame_end)
		else $error("result without byte does not end a frame");

	a_too_large_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_TOO_LARGE) |-> (!frame_end && !has_byte))
		else $error("too-large result carries frame data");
`endif

endmodule

>>> bench/deframe_checker.sv
// Checker for the WebSocket frame deframer: predicts each result from accepted bytes and compares.
module deframe_checker #(
	parameter int unsigned LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        has_byte,
	input  logic [7:0]  payload_byte,
	input  logic [3:0]  message_opcode,
	input  logic        frame_end,
	input  logic        message_end,
	input  logic [1:0]  event_res,
	output int          fail_count,
	output int          pending
);
	import wsdf_pkg::*;

	localparam logic [2:0] WAIT_HDR0  = 3'd0;
	localparam logic [2:0] WAIT_HDR1  = 3'd1;
	localparam logic [2:0] READ_EXT   = 3'd2;
	localparam logic [2:0] READ_KEY   = 3'd3;
	localparam logic [2:0] IN_PAYLOAD = 3'd4;
	localparam logic [2:0] HALTED     = 3'd5;

	logic [2:0]  phase = WAIT_HDR0;
	logic [2:0]  ext_left = '0;
	logic [63:0] remaining = '0;
	logic [31:0] key_word = '0;
	logic        key_on = 1'b0;
	logic [1:0]  key_pos = '0;
	logic        cur_fin = 1'b0;
	logic [3:0]  msg_opcode = '0;
	logic [32:0] msg_bytes = '0;
	logic [31:0] limit_bytes = MAX_MSG_RESET;
	res_t        due_results[$];

	task automatic clear_parser();
		phase = WAIT_HDR0;
		ext_left = '0;
		remaining = '0;
		key_word = '0;
		key_on = 1'b0;
		key_pos = '0;
		cur_fin = 1'b0;
		msg_opcode = '0;
		msg_bytes = '0;
		limit_bytes = MAX_MSG_RESET;
		due_results.delete();
	endtask

	task automatic expect_result(input logic has, input logic [7:0] value, input logic fend,
			input logic mend, input logic [1:0] ev);
		res_t r;
		r.has_byte = has;
		r.payload_byte = value;
		r.message_opcode = msg_opcode;
		r.frame_end = fend;
		r.message_end = mend;
		r.event_res = ev;
		due_results.push_back(r);
	endtask

	task automatic close_frame(input logic has, input logic [7:0] value);
		logic [1:0] ev;
		logic       halt;
		ev = EV_NONE;
		halt = 1'b0;
		if (cur_fin) begin
			if (msg_opcode == OPC_CLOSE) begin
				ev = EV_CLOSE;
				halt = 1'b1;
			end else if (msg_opcode == OPC_PING) begin
				ev = EV_PING;
			end
		end
		expect_result(has, value, 1'b1, cur_fin, ev);
		if (cur_fin) begin
			msg_opcode = '0;
			msg_bytes = '0;
		end
		phase = halt ? HALTED : WAIT_HDR0;
	endtask

	task automatic finish_header();
		key_pos = '0;
		if (remaining == 64'd0)
			close_frame(1'b0, 8'h00);
		else
			phase = IN_PAYLOAD;
	endtask

	task automatic check_length();
		logic [63:0] fit;
		logic [63:0] room;
		fit = (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);
		room = {32'd0, limit_bytes} - {31'd0, msg_bytes};
		if ((remaining & ~fit) != 64'd0 || msg_bytes > {1'b0, limit_bytes}
				|| remaining > room) begin
			expect_result(1'b0, 8'h00, 1'b0, 1'b0, EV_TOO_LARGE);
			phase = HALTED;
		end else begin
			msg_bytes = msg_bytes + remaining[32:0];
			key_word = '0;
			if (key_on) begin
				ext_left = 3'd3;
				phase = READ_KEY;
			end else begin
				finish_header();
			end
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [7:0] key;
		logic [7:0] plain;
		unique case (phase)
			WAIT_HDR0: begin
				cur_fin = b[7];
				if (msg_opcode == 4'h0)
					msg_opcode = b[3:0];
				phase = WAIT_HDR1;
			end
			WAIT_HDR1: begin
				key_on = b[7];
				remaining = '0;
				if (b[6:0] == LEN7_EXT16) begin
					ext_left = 3'd1;
					phase = READ_EXT;
				end else if (b[6:0] == LEN7_EXT64) begin
					ext_left = 3'd7;
					phase = READ_EXT;
				end else begin
					remaining = {57'd0, b[6:0]};
					check_length();
				end
			end
			READ_EXT: begin
				remaining = {remaining[55:0], b};
				if (ext_left != 3'd0)
					ext_left = ext_left - 3'd1;
				else
					check_length();
			end
			READ_KEY: begin
				key_word = {key_word[23:0], b};
				if (ext_left != 3'd0)
					ext_left = ext_left - 3'd1;
				else
					finish_header();
			end
			IN_PAYLOAD: begin
				key = key_on ? 8'(key_word >> (8 * (3 - int'(key_pos)))) : 8'h00;
				plain = b ^ key;
				key_pos = key_pos + 2'd1;
				remaining = remaining - 64'd1;
				if (remaining == 64'd0)
					close_frame(1'b1, plain);
				else
					expect_result(1'b1, plain, 1'b0, 1'b0, EV_NONE);
			end
			default: begin
				phase = HALTED;
			end
		endcase
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	task automatic compare_result();
		res_t want;
		if (due_results.size() == 0) begin
			$display("%0t: extra result, expected none, actual %0d %02h %0h %0d %0d %0d",
				$time, has_byte, payload_byte, message_opcode, frame_end, message_end,
				event_res);
			fail_count++;
		end else begin
			want = due_results.pop_front();
			check_field("has_byte", want.has_byte, has_byte);
			check_field("payload_byte", want.payload_byte, payload_byte);
			check_field("message_opcode", want.message_opcode, message_opcode);
			check_field("frame_end", want.frame_end, frame_end);
			check_field("message_end", want.message_end, message_end);
			check_field("event_res", want.event_res, event_res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				limit_bytes = cfg_wr_data;
			if (in_valid && !in_stall)
				parse_byte(data_byte);
			if (out_valid && !out_stall)
				compare_result();
			pending <= due_results.size();
		end
	end

endmodule

>>> bench/testbench.sv
// Testbench top for the WebSocket frame deframer: frame stimulus, receiver stalls and verdict.
module testbench;
	import wsdf_pkg::*;

	localparam int LEN_SHORT = 0;
	localparam int LEN_16    = 1;
	localparam int LEN_64    = 2;

	localparam logic [3:0] OPC_CONT   = 4'h0;
	localparam logic [3:0] OPC_TEXT   = 4'h1;
	localparam logic [3:0] OPC_BINARY = 4'h2;

	localparam int PHASE_BYTES = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        has_byte;
	logic [7:0]  payload_byte;
	logic [3:0]  message_opcode;
	logic        frame_end;
	logic        message_end;
	logic [1:0]  event_res;
	int          fail_count;
	int          pending;

	logic [3:0]  gen_held = '0;
	longint      gen_total = 0;
	longint      gen_limit = 65536;
	logic        last_fin = 1'b1;
	logic        tx_quiet = 1'b0;
	logic        rx_quiet = 1'b0;
	int          hold_cnt = 0;
	int          bytes_sent = 0;
	int          frames_sent = 0;
	int          settings = 0;

	websocket_frame_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.has_byte(has_byte),
		.payload_byte(payload_byte),
		.message_opcode(message_opcode),
		.frame_end(frame_end),
		.message_end(message_end),
		.event_res(event_res)
	);

	deframe_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.has_byte(has_byte),
		.payload_byte(payload_byte),
		.message_opcode(message_opcode),
		.frame_end(frame_end),
		.message_end(message_end),
		.event_res(event_res),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

	// stall the receiver at random after each taken result, with quiet stretches
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			int w;
			if ($urandom_range(0, 39) == 0)
				rx_quiet = ~rx_quiet;
			w = rx_quiet ? 0 : $urandom_range(0, 3);
			hold_cnt <= w;
			out_stall <= (w != 0);
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= (hold_cnt > 1);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int g;
		if ($urandom_range(0, 39) == 0)
			tx_quiet = ~tx_quiet;
		g = tx_quiet ? 0 : $urandom_range(0, 3);
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic fin, input logic [3:0] opc, input logic masked,
			input int form, input logic [63:0] len, input logic [2:0] rsv);
		send_byte({fin, rsv, opc});
		case (form)
			LEN_16:  send_byte({masked, LEN7_EXT16});
			LEN_64:  send_byte({masked, LEN7_EXT64});
			default: send_byte({masked, len[6:0]});
		endcase
		if (form == LEN_16) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end else if (form == LEN_64) begin
			for (int i = 7; i >= 0; i--)
				send_byte(len[8*i +: 8]);
		end
		if (masked)
			repeat (4) send_byte(8'($urandom_range(0, 255)));
		for (longint i = 0; i < longint'(len); i++)
			send_byte(8'($urandom_range(0, 255)));
		if (gen_held == OPC_CONT)
			gen_held = opc;
		gen_total += longint'(len);
		if (fin) begin
			gen_held = OPC_CONT;
			gen_total = 0;
		end
		last_fin = fin;
		frames_sent++;
	endtask

	task automatic random_frame();
		logic        fin;
		logic [3:0]  opc;
		logic [2:0]  rsv;
		logic [63:0] len;
		longint      room;
		int          r;
		int          form;
		fin = ($urandom_range(0, 9) < 7);
		opc = 4'($urandom_range(0, 15));
		// never open a message as a close; that would end the run early
		if (gen_held == OPC_CONT && opc == OPC_CLOSE)
			opc = OPC_TEXT;
		rsv = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			form = LEN_SHORT;
			len = 64'($urandom_range(0, 12));
		end else if (r < 85) begin
			form = LEN_SHORT;
			len = 64'($urandom_range(0, 125));
		end else if (r < 95) begin
			form = LEN_16;
			len = 64'($urandom_range(0, 300));
		end else begin
			form = LEN_64;
			len = 64'($urandom_range(0, 40));
		end
		room = gen_limit - gen_total;
		if (longint'(len) > room)
			len = 64'(room);
		send_frame(fin, opc, 1'($urandom_range(0, 1)), form, len, rsv);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gen_limit = longint'(value);
		settings++;
	endtask

	initial begin
		logic [31:0] limits[5];
		int          ending;
		limits[0] = 32'd1;
		limits[1] = 32'hFFFF_FFFF;
		limits[2] = 32'($urandom_range(2, 40));
		limits[3] = 32'd16;
		limits[4] = MAX_MSG_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(1'b1, OPC_TEXT, 1'b0, LEN_SHORT, 64'd0, 3'd0);
		send_frame(1'b1, OPC_BINARY, 1'b1, LEN_SHORT, 64'd0, 3'd0);
		send_frame(1'b0, OPC_TEXT, 1'b0, LEN_SHORT, 64'd1, 3'd0);
		send_frame(1'b1, OPC_CLOSE, 1'b0, LEN_SHORT, 64'd0, 3'd0);
		send_frame(1'b1, OPC_PING, 1'b1, LEN_SHORT, 64'd1, 3'd0);
		send_frame(1'b0, OPC_CONT, 1'b0, LEN_SHORT, 64'd0, 3'b111);
		send_frame(1'b1, OPC_PING, 1'b0, LEN_16, 64'd0, 3'd0);
		wait_idle();

		foreach (limits[p]) begin
			write_limit(limits[p]);
			while (bytes_sent < (p + 1) * PHASE_BYTES)
				random_frame();
			if (!last_fin)
				send_frame(1'b1, OPC_TEXT, 1'b0, LEN_SHORT, 64'd0, 3'd0);
			wait_idle();
		end

		// end on a close or an oversize message, then drop noise
		ending = $urandom_range(0, 1);
		if (ending == 0) begin
			send_frame(1'b1, OPC_CLOSE, 1'($urandom_range(0, 1)), LEN_SHORT,
				64'($urandom_range(0, 3)), 3'd0);
		end else begin
			send_frame(1'b0, OPC_TEXT, 1'b0, LEN_SHORT, 64'd1, 3'd0);
			send_byte({1'b1, 3'd0, OPC_CONT});
			send_byte({1'b0, LEN7_EXT64});
			for (int i = 7; i >= 0; i--)
				send_byte(8'(64'(gen_limit) >> (8 * i)));
		end
		repeat (40) send_byte(8'($urandom_range(0, 255)));
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Covered %0d bytes in %0d frames over %0d limit settings,", bytes_sent,
			frames_sent, settings);
		$display("ending with %s and trailing noise.", ending == 0 ? "a close frame" :
			"an oversize message");
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/wsdf_pkg.sv
design/websocket_frame_deframer_unit.sv
bench/deframe_checker.sv
bench/testbench.sv
